/* sv/peak_mean_amplitude_meter_assert.svh */
// Assertion macros shared by the peak and mean amplitude meter modules.
// Needs no other file; the modules that assert include it by name.
`ifndef PEAK_MEAN_AMPLITUDE_METER_ASSERT_SVH
`define PEAK_MEAN_AMPLITUDE_METER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PMAM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PMAM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PMAM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define PMAM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* sv/pmam_pkg.sv */
// Types and constants for the peak and mean amplitude meter.
// Depends on nothing; pmam_accum and the top level import it.
`timescale 1ns / 1ps

package pmam_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int MAX_SAMPLES_DEF = 65536;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mean_value;
      logic [SAMPLE_W-1:0]        peak_dc;
      logic [SAMPLE_W-1:0]        peak_ac;
   } rsp_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] lo;
      logic signed [SAMPLE_W-1:0] hi;
   } extremes_type;

endpackage

/* sv/pmam_divider.sv */
// Restoring unsigned divider that produces one quotient bit per cycle.
// Depends on peak_mean_amplitude_meter_assert.svh for its assertions.
`timescale 1ns / 1ps
`include "peak_mean_amplitude_meter_assert.svh"

module pmam_divider #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W+1:0] diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, den_ff};
   assign fits  = !diff[DEN_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = denom;
         quo_in  = numer;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

   `PMAM_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff, "divider did not start")
   `PMAM_ASSERT_IMPLY(a_done_idle, clock, reset, done_ff, !busy_ff, "divider done while busy")

endmodule

/* sv/pmam_accum.sv */
// Running minimum, maximum, sum and sample count of the current capture.
// Depends on pmam_pkg and peak_mean_amplitude_meter_assert.svh.
`timescale 1ns / 1ps
`include "peak_mean_amplitude_meter_assert.svh"

module pmam_accum import pmam_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int SUM_W       = 32,
   parameter int TALLY_W     = 17
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       take,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic                       clear,
   output extremes_type               extremes,
   output logic signed [SUM_W-1:0]    sum,
   output logic [TALLY_W-1:0]         tally
);

   extremes_type             ext_ff, ext_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [TALLY_W-1:0]       tally_ff, tally_in;
   logic                     full;

   assign full = tally_ff >= TALLY_W'(MAX_SAMPLES);

   always_comb begin
      ext_in   = ext_ff;
      sum_in   = sum_ff;
      tally_in = tally_ff;
      if (clear) begin
         ext_in   = '0;
         sum_in   = '0;
         tally_in = '0;
      end else if (take && !full) begin
         if (tally_ff == '0) begin
            ext_in.lo = sample;
            ext_in.hi = sample;
         end else begin
            if (sample < ext_ff.lo) begin
               ext_in.lo = sample;
            end
            if (sample > ext_ff.hi) begin
               ext_in.hi = sample;
            end
         end
         sum_in   = sum_ff + SUM_W'(sample);
         tally_in = tally_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff   <= '0;
         sum_ff   <= '0;
         tally_ff <= '0;
      end else begin
         ext_ff   <= ext_in;
         sum_ff   <= sum_in;
         tally_ff <= tally_in;
      end
   end

   assign extremes = ext_ff;
   assign sum      = sum_ff;
   assign tally    = tally_ff;

   `PMAM_ASSERT_IMPLY(a_tally_cap, clock, reset, 1'b1, tally_ff <= TALLY_W'(MAX_SAMPLES), "count beyond limit")
   `PMAM_ASSERT_IMPLY(a_order, clock, reset, tally_ff != '0, ext_ff.lo <= ext_ff.hi, "minimum above maximum")
   `PMAM_ASSERT_NEXT(a_clear, clock, reset, clear, tally_ff == '0 && sum_ff == '0, "clear failed")

endmodule

/* sv/peak_mean_amplitude_meter.sv */
// Channel   Direction  Word      Handshake
// req       in         req_type  req_valid / req_stall
// rsp       out        rsp_type  rsp_valid / rsp_stall
//
// Words without the last flag flow at one per cycle while no last word is in progress.
// After a last word the block steps through ST_START, ST_DIVIDE and ST_FINISH: the mean
// comes from the bit-serial divider, one quotient bit per cycle; ST_FINISH forms the peaks.
// A waiting result holds the block in ST_FINISH until the previous one is taken.
// Reset is synchronous and clears the running figures; no memory needs a clearing pass.
// Top level; depends on pmam_pkg, pmam_accum, pmam_divider and the assertion header.
`timescale 1ns / 1ps
`include "peak_mean_amplitude_meter_assert.svh"

module peak_mean_amplitude_meter import pmam_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   localparam int TALLY_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W   = SAMPLE_W + $clog2(MAX_SAMPLES);
   localparam int EXT_W   = SAMPLE_W + 2;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_START,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type               state_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;
   logic                    neg_ff;

   logic                    req_accept;
   logic                    rsp_free;
   extremes_type            extremes;
   logic signed [SUM_W-1:0] sum;
   logic [TALLY_W-1:0]      tally;
   logic [SUM_W-1:0]        sum_mag;
   logic                    div_start;
   logic                    div_done;
   logic [SUM_W-1:0]        quot;
   logic [SAMPLE_W-1:0]     mean;
   logic signed [EXT_W-1:0] lo_x, hi_x, mean_x, abs_lo, d_hi, d_lo, abs_dlo, dc_x, ac_x;

   assign req_stall  = state_ff != ST_RUN;
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign div_start  = state_ff == ST_START;
   assign sum_mag    = sum[SUM_W-1] ? (~sum + 1'b1) : sum;

   pmam_accum #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .SUM_W      (SUM_W),
      .TALLY_W    (TALLY_W)
   ) u_accum (
      .clock   (clock),
      .reset   (reset),
      .take    (req_accept),
      .sample  (req_word.sample),
      .clear   (state_ff == ST_FINISH && rsp_free),
      .extremes(extremes),
      .sum     (sum),
      .tally   (tally)
   );

   pmam_divider #(
      .NUM_W(SUM_W),
      .DEN_W(TALLY_W)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numer(sum_mag),
      .denom(tally),
      .done (div_done),
      .quot (quot)
   );

   always_comb begin
      mean    = neg_ff ? (~quot[SAMPLE_W-1:0] + 1'b1) : quot[SAMPLE_W-1:0];
      lo_x    = EXT_W'(extremes.lo);
      hi_x    = EXT_W'(extremes.hi);
      mean_x  = EXT_W'($signed(mean));
      abs_lo  = (lo_x < 0) ? -lo_x : lo_x;
      dc_x    = (hi_x > abs_lo) ? hi_x : abs_lo;
      d_hi    = hi_x - mean_x;
      d_lo    = lo_x - mean_x;
      abs_dlo = (d_lo < 0) ? -d_lo : d_lo;
      ac_x    = (d_hi > abs_dlo) ? d_hi : abs_dlo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_RUN: begin
               if (req_accept && req_word.last) begin
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               neg_ff   <= sum[SUM_W-1];
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  rsp_ff.mean_value <= $signed(mean);
                  rsp_ff.peak_dc    <= dc_x[SAMPLE_W-1:0];
                  rsp_ff.peak_ac    <= ac_x[SAMPLE_W-1:0];
                  rsp_valid_ff      <= 1'b1;
                  state_ff          <= ST_RUN;
               end
            end
            default: begin
               state_ff <= ST_RUN;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `PMAM_ASSERT_NEXT(a_last_starts, clock, reset, req_accept && req_word.last, state_ff == ST_START, "last word did not start division")
   `PMAM_ASSERT_IMPLY(a_done_in_divide, clock, reset, div_done, state_ff == ST_DIVIDE, "division finished out of turn")
   `PMAM_ASSERT_NEXT(a_finish_loads, clock, reset, state_ff == ST_FINISH && rsp_free, rsp_valid && state_ff == ST_RUN, "result not presented")

endmodule
